>>> src/slmrf_pkg.sv
`timescale 1ns / 1ps
package slmrf_pkg;

    // Display geometry
    localparam int MATRIX_COUNT   = 12;
    localparam int M_W            = (MATRIX_COUNT > 1) ? $clog2(MATRIX_COUNT) : 1;
    localparam int UPPER_COUNT    = 6;
    localparam int LOWER_COL_BASE = 11;
    localparam int LOWER_ROW_BASE = 15;
    localparam int NARROW_ROWS    = 24;
    localparam int VOFF_MAX       = 16;

    // Frame stores
    localparam int NARROW_DEPTH = 144;
    localparam int NARROW_AW    = $clog2(NARROW_DEPTH);
    localparam int WIDE_DEPTH   = 256;
    localparam int WIDE_AW      = $clog2(WIDE_DEPTH);

    // Queues
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PW    = $clog2(CMD_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_FETCH = 1'b1
    } req_e_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH
    } state_e_t;

    // Classified request, front to back
    typedef struct packed {
        logic                 is_fetch;
        logic                 wr_narrow;
        logic                 wr_wide;
        logic [NARROW_AW-1:0] narrow_addr;
        logic [WIDE_AW-1:0]   wide_addr;
        logic [7:0]           wr_byte;
        logic [2:0]           scan;
        logic [4:0]           voff;
        logic [4:0]           byte_off;
        logic [2:0]           bit_sh;
    } cmd_t;

    typedef struct packed {
        logic [3:0] digit;
        logic [7:0] seg;
        logic       last;
    } result_t;

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

>>> src/slmrf_ram.sv
`timescale 1ns / 1ps
module slmrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/slmrf_front.sv
`timescale 1ns / 1ps
module slmrf_front
    import slmrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       req_type,
    input  logic [4:0] frame_row,
    input  logic [4:0] frame_col,
    input  logic [7:0] frame_byte,
    input  logic [2:0] scan_row,
    input  logic [4:0] vertical_offset,
    input  logic [7:0] horizontal_offset,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    cmd_t              cmd_in;
    cmd_t              slot_reg [CMD_DEPTH];
    logic [CMD_PW-1:0] wptr_reg, wptr_next;
    logic [CMD_PW-1:0] rptr_reg, rptr_next;
    logic [CMD_PW:0]   count_reg, count_next;
    logic              do_push, do_pop;
    logic              is_write;

    // Classify: decode write target and address, clamp the vertical offset
    always_comb
    begin
        is_write            = (req_type == REQ_WRITE);
        cmd_in.is_fetch     = (req_type == REQ_FETCH);
        cmd_in.wr_narrow    = is_write && (frame_row < 5'(NARROW_ROWS))
                              && (frame_col < 5'(UPPER_COUNT));
        cmd_in.wr_wide      = is_write && (frame_row >= 5'(NARROW_ROWS));
        cmd_in.narrow_addr  = NARROW_AW'({frame_row, 2'b00})
                              + NARROW_AW'({frame_row, 1'b0})
                              + NARROW_AW'(frame_col);
        cmd_in.wide_addr    = {frame_row[2:0], frame_col};
        cmd_in.wr_byte      = frame_byte;
        cmd_in.scan         = scan_row;
        cmd_in.voff         = (vertical_offset > 5'(VOFF_MAX)) ? 5'(VOFF_MAX)
                                                               : vertical_offset;
        cmd_in.byte_off     = horizontal_offset[7:3];
        cmd_in.bit_sh       = horizontal_offset[2:0];
    end

    assign full      = (count_reg == (CMD_PW + 1)'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (CMD_PW + 1)'(do_push) - (CMD_PW + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

>>> src/slmrf_back.sv
`timescale 1ns / 1ps
module slmrf_back
    import slmrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [3:0] digit_address,
    output logic [7:0] segment_byte,
    output logic       last_matrix
);

    localparam logic [M_W-1:0] M_LAST = M_W'(MATRIX_COUNT - 1);

    state_e_t state_reg, state_next;

    // Fetch context
    logic [2:0]     scan_reg;
    logic [4:0]     voff_reg;
    logic [4:0]     boff_reg;
    logic [2:0]     bsh_reg;
    logic [M_W-1:0] m_reg, m_next;

    logic issue, credit_ok, fetch_start;
    logic wr_narrow, wr_wide;

    // Clearing pass after reset
    logic               clr_we;
    logic [WIDE_AW-1:0] clr_addr_reg, clr_addr_next;

    // Store write port
    logic                 narrow_we, wide_we;
    logic [NARROW_AW-1:0] narrow_waddr;
    logic [WIDE_AW-1:0]   wide_waddr;
    logic [7:0]           wr_data;

    // Read address generation
    logic                 upper;
    logic [4:0]           row;
    logic [4:0]           col;
    logic                 col_ok;
    logic [4:0]           c0, c1;
    logic [NARROW_AW-1:0] narrow_raddr;
    logic [WIDE_AW-1:0]   wide_raddr0, wide_raddr1;

    // Read stage
    logic       rd_valid_reg;
    logic       rd_narrow_reg, rd_colok_reg, rd_lower_reg, rd_last_reg;
    logic [2:0] rd_bsh_reg;
    logic [3:0] rd_digit_reg;
    logic [7:0] ndata, wdata0, wdata1;

    // Result assembly
    logic [7:0]  nbyte, w0, w1, pix;
    logic [15:0] funnel;
    result_t     res;

    // Output queue
    result_t           oq_reg [OUT_DEPTH];
    logic [OUT_PW-1:0] owp_reg, orp_reg;
    logic [OUT_PW:0]   ocnt_reg, ocnt_next;
    logic              oq_pop;
    result_t           head;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == WIDE_AW'(WIDE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && cmd.is_fetch)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (issue && (m_reg == M_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // One read in flight at most, plus queued results, must fit the output queue
    assign credit_ok = ((OUT_PW + 1)'(ocnt_reg) + (OUT_PW + 1)'(rd_valid_reg))
                       < (OUT_PW + 1)'(OUT_DEPTH);

    always_comb
    begin
        cmd_pop     = 1'b0;
        issue       = 1'b0;
        fetch_start = 1'b0;
        wr_narrow   = 1'b0;
        wr_wide     = 1'b0;
        clr_we      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_we = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_pop     = cmd_valid;
                fetch_start = cmd_valid && cmd.is_fetch;
                wr_narrow   = cmd_valid && cmd.wr_narrow;
                wr_wide     = cmd_valid && cmd.wr_wide;
            end
            ST_FETCH:
            begin
                issue = credit_ok;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        m_next = m_reg;
        if (fetch_start)
        begin
            m_next = '0;
        end
        else if (issue)
        begin
            m_next = m_reg + 1'b1;
        end
        clr_addr_next = clr_we ? clr_addr_reg + 1'b1 : clr_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            m_reg        <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_reg        <= m_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_start)
        begin
            scan_reg <= cmd.scan;
            voff_reg <= cmd.voff;
            boff_reg <= cmd.byte_off;
            bsh_reg  <= cmd.bit_sh;
        end
    end

    // ---------------- address generation ----------------
    always_comb
    begin
        upper  = (6'(m_reg) < 6'(UPPER_COUNT));
        row    = upper ? (5'(scan_reg) + voff_reg)
                       : (5'(LOWER_ROW_BASE) - 5'(scan_reg) + voff_reg);
        col    = upper ? 5'(m_reg) : (5'(LOWER_COL_BASE) - 5'(m_reg));
        // lower matrices past the narrow width have no narrow column
        col_ok = (6'(m_reg) < 6'(2 * UPPER_COUNT));
        narrow_raddr = NARROW_AW'({row, 2'b00}) + NARROW_AW'({row, 1'b0})
                       + NARROW_AW'(col[2:0]);
        c0 = col + boff_reg;
        c1 = c0 + 5'd1;
        wide_raddr0 = {row[2:0], c0};
        wide_raddr1 = {row[2:0], c1};
    end

    // ---------------- frame stores ----------------
    // clearing pass zeroes every entry; request writes follow it
    always_comb
    begin
        narrow_we    = wr_narrow
                       || (clr_we && (clr_addr_reg < WIDE_AW'(NARROW_DEPTH)));
        narrow_waddr = clr_we ? NARROW_AW'(clr_addr_reg) : cmd.narrow_addr;
        wide_we      = wr_wide || clr_we;
        wide_waddr   = clr_we ? clr_addr_reg : cmd.wide_addr;
        wr_data      = clr_we ? 8'd0 : cmd.wr_byte;
    end

    slmrf_ram #(.WIDTH(8), .DEPTH(NARROW_DEPTH)) u_narrow (
        .clk   (clk),
        .we    (narrow_we),
        .waddr (narrow_waddr),
        .wdata (wr_data),
        .raddr (narrow_raddr),
        .rdata (ndata)
    );

    // Wide store kept twice so both funnel columns are read in the same cycle
    slmrf_ram #(.WIDTH(8), .DEPTH(WIDE_DEPTH)) u_wide_a (
        .clk   (clk),
        .we    (wide_we),
        .waddr (wide_waddr),
        .wdata (wr_data),
        .raddr (wide_raddr0),
        .rdata (wdata0)
    );

    slmrf_ram #(.WIDTH(8), .DEPTH(WIDE_DEPTH)) u_wide_b (
        .clk   (clk),
        .we    (wide_we),
        .waddr (wide_waddr),
        .wdata (wr_data),
        .raddr (wide_raddr1),
        .rdata (wdata1)
    );

    // ---------------- read stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_narrow_reg <= (row < 5'(NARROW_ROWS));
        rd_colok_reg  <= col_ok;
        rd_lower_reg  <= !upper;
        rd_last_reg   <= (m_reg == M_LAST);
        rd_bsh_reg    <= bsh_reg;
        rd_digit_reg  <= 4'(scan_reg) + 4'd1;
    end

    always_comb
    begin
        nbyte      = rd_colok_reg ? ndata : 8'd0;
        w0         = wdata0;
        w1         = wdata1;
        funnel     = {w0, w1} << rd_bsh_reg;
        pix        = rd_narrow_reg ? nbyte : funnel[15:8];
        res.digit  = rd_digit_reg;
        res.seg    = rd_lower_reg ? bit_rev8(pix) : pix;
        res.last   = rd_last_reg;
    end

    // ---------------- output queue ----------------
    assign empty  = (ocnt_reg == '0);
    assign oq_pop = pop && !empty;
    assign head   = oq_reg[orp_reg];

    assign digit_address = head.digit;
    assign segment_byte  = head.seg;
    assign last_matrix   = head.last;

    always_comb
    begin
        ocnt_next = ocnt_reg + (OUT_PW + 1)'(rd_valid_reg) - (OUT_PW + 1)'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= '0;
            orp_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (rd_valid_reg)
            begin
                owp_reg <= owp_reg + 1'b1;
            end
            if (oq_pop)
            begin
                orp_reg <= orp_reg + 1'b1;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            oq_reg[owp_reg] <= res;
        end
    end

endmodule

>>> src/scrolling_led_matrix_row_fetch.sv
`timescale 1ns / 1ps
// Row fetch for a scrolling display of 8x8 LED matrices.
//
// Request side is a queue: drive a request with push while full is low.
// req_type selects a frame byte write (frame_row/frame_col/frame_byte) or a
// scan row fetch (scan_row, vertical_offset, horizontal_offset).
// Result side is a queue too: while empty is low the oldest result sits on
// digit_address/segment_byte/last_matrix; pop takes it.
//
// A fetch yields one result per matrix, upper matrices first, last_matrix set
// on the final one. A write yields nothing.
// A write needs only its dispatch step in the single read sequencer; a fetch
// adds one frame-store read per matrix, and the next request waits until the
// last read. The first result passes the request queue, the fetch state, the
// read stage and the result queue before it shows.
// A two-entry request queue separates request decode from the sequencer, and
// a four-entry result queue lets the sequencer keep reading while the
// receiver stalls; it pauses only when that queue would overflow.
// Reset empties both queues, then a clearing pass zeroes the frame stores one
// address a cycle through all addresses; requests wait (full once two are queued).
module scrolling_led_matrix_row_fetch
    import slmrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       req_type,
    input  logic [4:0] frame_row,
    input  logic [4:0] frame_col,
    input  logic [7:0] frame_byte,
    input  logic [2:0] scan_row,
    input  logic [4:0] vertical_offset,
    input  logic [7:0] horizontal_offset,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] digit_address,
    output logic [7:0] segment_byte,
    output logic       last_matrix
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // front: take requests, decode, queue
    slmrf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .req_type          (req_type),
        .frame_row         (frame_row),
        .frame_col         (frame_col),
        .frame_byte        (frame_byte),
        .scan_row          (scan_row),
        .vertical_offset   (vertical_offset),
        .horizontal_offset (horizontal_offset),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_pop           (cmd_pop)
    );

    // back: frame stores, read sequencer, result queue
    slmrf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .pop           (pop),
        .empty         (empty),
        .digit_address (digit_address),
        .segment_byte  (segment_byte),
        .last_matrix   (last_matrix)
    );

endmodule

>>> src/slmrf_checker.sv
`timescale 1ns / 1ps
module slmrf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pop,
    input logic       empty,
    input logic [3:0] digit_address,
    input logic [7:0] segment_byte,
    input logic       last_matrix
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digit_address)
                              && $stable(segment_byte) && $stable(last_matrix)))
        else $error("stalled result changed");

    // digit address is scan row plus one
    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (digit_address >= 4'd1 && digit_address <= 4'd8))
        else $error("digit address out of range");

    // results of one fetch share the scan row
    a_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_matrix) |=>
            (empty || digit_address == $past(digit_address)))
        else $error("scan row changed inside a fetch");

endmodule

bind scrolling_led_matrix_row_fetch slmrf_checker u_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import slmrf_pkg::*;

    // A single request, as offered on the push side. Fields that the request
    // kind does not use still carry random values.
    typedef struct {
        req_e_t     kind;
        logic [4:0] row;
        logic [4:0] col;
        logic [7:0] data;
        logic [2:0] scan;
        logic [4:0] voff;
        logic [7:0] hoff;
        bit         drain_first; // hold this request until all segments are out
        bit         steady;      // sender never idles on this request
    } request_t;

    // One expected matrix segment.
    typedef struct {
        logic [3:0] digit;
        logic [7:0] seg;
        logic       last;
    } segment_t;

    localparam int RANDOM_REQUESTS = 200;
    localparam int HOLD_AT_RESULT  = 150;  // receiver starts its long hold here
    localparam int HOLD_CYCLES     = 80;
    localparam int CALM_FIRST      = 400;  // receiver window with no stalls
    localparam int CALM_LAST       = 700;
    localparam int SETTLE_CYCLES   = 40;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       req_type = 1'b0;
    logic [4:0] frame_row = '0;
    logic [4:0] frame_col = '0;
    logic [7:0] frame_byte = '0;
    logic [2:0] scan_row = '0;
    logic [4:0] vertical_offset = '0;
    logic [7:0] horizontal_offset = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [3:0] digit_address;
    logic [7:0] segment_byte;
    logic       last_matrix;

    // Shadow frame: mirrors what the block should hold after each request.
    logic [7:0] narrow_frame [NARROW_DEPTH] = '{default: '0};
    logic [7:0] wide_frame [WIDE_DEPTH] = '{default: '0};

    request_t request_queue [$];   // requests not yet taken by the block
    segment_t segment_queue [$];   // segments predicted but not yet popped

    int errors = 0;
    int segments_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    scrolling_led_matrix_row_fetch i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .req_type          (req_type),
        .frame_row         (frame_row),
        .frame_col         (frame_col),
        .frame_byte        (frame_byte),
        .scan_row          (scan_row),
        .vertical_offset   (vertical_offset),
        .horizontal_offset (horizontal_offset),
        .empty             (empty),
        .pop               (pop),
        .digit_address     (digit_address),
        .segment_byte      (segment_byte),
        .last_matrix       (last_matrix)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // Byte of virtual row 'row' at column 'col' as the view sees it.
    // Narrow rows have six columns, anything else reads zero. Wide rows
    // wrap mod 32, take the byte offset, and funnel in the next column.
    function automatic logic [7:0] view_byte(input int row, input int col,
                                             input int byte_off,
                                             input int bit_sh);
        int         wrow;
        int         c;
        logic [15:0] pair;
        if (row < NARROW_ROWS)
        begin
            if (col >= UPPER_COUNT)
            begin
                return 8'h00;
            end
            return narrow_frame[row * UPPER_COUNT + col];
        end
        wrow = (row - NARROW_ROWS) & 7;
        c    = (col + byte_off) & 31;
        pair = {wide_frame[wrow * 32 + c], wide_frame[wrow * 32 + ((c + 1) & 31)]};
        pair = pair << bit_sh;
        return pair[15:8];
    endfunction

    // Applies one taken request to the shadow frame and queues the segments
    // that a fetch has to produce.
    task automatic apply_request(input request_t r);
        int       voff;
        int       byte_off;
        int       bit_sh;
        int       row;
        int       col;
        segment_t s;
        if (r.kind == REQ_WRITE)
        begin
            if (r.row < NARROW_ROWS)
            begin
                // columns past the narrow width are dropped
                if (r.col < UPPER_COUNT)
                begin
                    narrow_frame[r.row * UPPER_COUNT + r.col] = r.data;
                end
            end
            else
            begin
                wide_frame[(r.row - NARROW_ROWS) * 32 + r.col] = r.data;
            end
            return;
        end
        voff     = (r.voff > VOFF_MAX) ? VOFF_MAX : r.voff;
        byte_off = r.hoff[7:3];
        bit_sh   = r.hoff[2:0];
        for (int m = 0; m < MATRIX_COUNT; m++)
        begin
            s.digit = r.scan + 4'd1;
            s.last  = (m == MATRIX_COUNT - 1);
            if (m < UPPER_COUNT)
            begin
                row   = r.scan + voff;
                s.seg = view_byte(row, m, byte_off, bit_sh);
            end
            else
            begin
                // lower half is mounted upside down: rows and columns run
                // backwards and each byte is mirrored
                row   = LOWER_ROW_BASE - r.scan + voff;
                col   = (LOWER_COL_BASE - m) & 8'hFF;
                s.seg = mirror8(view_byte(row, col, byte_off, bit_sh));
            end
            segment_queue.push_back(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Request builders; unused fields are randomized
    // ------------------------------------------------------------------

    function automatic request_t make_write(input logic [4:0] row,
                                            input logic [4:0] col,
                                            input logic [7:0] data);
        request_t r;
        r.kind        = REQ_WRITE;
        r.row         = row;
        r.col         = col;
        r.data        = data;
        r.scan        = 3'($urandom_range(0, 7));
        r.voff        = 5'($urandom_range(0, 31));
        r.hoff        = 8'($urandom_range(0, 255));
        r.drain_first = 1'b0;
        r.steady      = 1'b0;
        return r;
    endfunction

    function automatic request_t make_fetch(input logic [2:0] scan,
                                            input logic [4:0] voff,
                                            input logic [7:0] hoff);
        request_t r;
        r.kind        = REQ_FETCH;
        r.row         = 5'($urandom_range(0, 31));
        r.col         = 5'($urandom_range(0, 31));
        r.data        = 8'($urandom_range(0, 255));
        r.scan        = scan;
        r.voff        = voff;
        r.hoff        = hoff;
        r.drain_first = 1'b0;
        r.steady      = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the head of request_queue. A request that meets full
    // stays on the port unchanged until the block takes it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic     offer;
        request_t head;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                apply_request(request_queue.pop_front());
            end
            if (push && full)
            begin
                offer = 1'b1;
            end
            else if (request_queue.size() == 0)
            begin
                offer = 1'b0;
            end
            else if (request_queue[0].drain_first && segment_queue.size() != 0)
            begin
                // sender pause: let the result side run dry first
                offer = 1'b0;
            end
            else if (!request_queue[0].steady && $urandom_range(0, 99) < 20)
            begin
                offer = 1'b0;
            end
            else
            begin
                offer = 1'b1;
            end
            push <= offer;
            if (offer)
            begin
                head = request_queue[0];
                req_type          <= head.kind;
                frame_row         <= head.row;
                frame_col         <= head.col;
                frame_byte        <= head.data;
                scan_row          <= head.scan;
                vertical_offset   <= head.voff;
                horizontal_offset <= head.hoff;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every popped segment against the oldest prediction
    // and decides when the receiver stalls.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        segment_t want;
        logic     take;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (segment_queue.size() == 0)
                begin
                    $error("unexpected segment: digit_address %0d segment_byte %02h",
                           digit_address, segment_byte);
                    errors++;
                end
                else
                begin
                    want = segment_queue.pop_front();
                    if (digit_address !== want.digit)
                    begin
                        $error("digit_address: expected %0d, got %0d",
                               want.digit, digit_address);
                        errors++;
                    end
                    if (segment_byte !== want.seg)
                    begin
                        $error("segment_byte: expected %02h, got %02h",
                               want.seg, segment_byte);
                        errors++;
                    end
                    if (last_matrix !== want.last)
                    begin
                        $error("last_matrix: expected %0d, got %0d",
                               want.last, last_matrix);
                        errors++;
                    end
                end
                segments_seen++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (!hold_done && segments_seen >= HOLD_AT_RESULT)
            begin
                // long receiver hold: both queues in the block fill and
                // full must come up while the sender keeps pushing
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                take      = 1'b0;
            end
            else if (segments_seen >= CALM_FIRST && segments_seen < CALM_LAST)
            begin
                take = 1'b1;
            end
            else
            begin
                take = ($urandom_range(0, 99) >= 20);
            end
            pop <= take;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        request_t r;

        // directed: store extremes, ignored narrow columns, wrap corners
        request_queue.push_back(make_write(5'd0, 5'd0, 8'hFF));
        request_queue.push_back(make_write(5'd23, 5'd5, 8'h80));
        request_queue.push_back(make_write(5'd5, 5'd31, 8'hAA));   // dropped
        request_queue.push_back(make_write(5'd0, 5'd6, 8'h55));    // dropped
        request_queue.push_back(make_write(5'd8, 5'd2, 8'h3C));
        request_queue.push_back(make_write(5'd24, 5'd0, 8'h01));
        request_queue.push_back(make_write(5'd31, 5'd31, 8'hFF));
        request_queue.push_back(make_write(5'd31, 5'd0, 8'h81));
        request_queue.push_back(make_write(5'd28, 5'd17, 8'hC3));
        request_queue.push_back(make_fetch(3'd0, 5'd0, 8'h00));
        request_queue.push_back(make_fetch(3'd7, 5'd16, 8'hFF));
        request_queue.push_back(make_fetch(3'd0, 5'd31, 8'h07));   // offset saturates
        request_queue.push_back(make_fetch(3'd7, 5'd17, 8'hF8));
        request_queue.push_back(make_fetch(3'd3, 5'd9, 8'h01));
        request_queue.push_back(make_fetch(3'd0, 5'd16, 8'h04));   // lower matrices read row 31
        request_queue.push_back(make_fetch(3'd7, 5'd0, 8'h00));
        request_queue.push_back(make_fetch(3'd5, 5'd13, 8'h7B));

        // random mix; wide rows get half the writes so fetched data is busy
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    r = make_write(5'($urandom_range(24, 31)),
                                   5'($urandom_range(0, 31)),
                                   8'($urandom_range(0, 255)));
                end
                else
                begin
                    r = make_write(5'($urandom_range(0, 23)),
                                   5'(($urandom_range(0, 99) < 85) ?
                                       $urandom_range(0, 5) : $urandom_range(0, 31)),
                                   8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                r = make_fetch(3'($urandom_range(0, 7)),
                               5'(($urandom_range(0, 99) < 85) ?
                                   $urandom_range(0, 16) : $urandom_range(17, 31)),
                               8'($urandom_range(0, 255)));
            end
            r.steady      = (i >= 100 && i < 150);
            r.drain_first = (i == 160);
            request_queue.push_back(r);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || segment_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
